@@ rtl/core/lfpid_pkg.sv @@
`timescale 1ns / 1ps

package lfpid_pkg;

    // field widths
    localparam int THR_W   = 14;
    localparam int GAIN_W  = 12;
    localparam int BASE_W  = 8;
    localparam int ELAP_W  = 16;
    localparam int RUN_W   = 16;
    localparam int ERR_W   = 4;
    localparam int DRIVE_W = 17;
    localparam int CMD_W   = 2;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W = 3;

    // shared multiplier and divider widths
    localparam int NUM_W = 16;
    localparam int DEN_W = 32;
    localparam int SUM_W = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

    // actions
    localparam logic [ACT_W-1:0] ACT_STEER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BRAKE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_IDLE  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_EARLY = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd5;

    // line error values
    localparam logic signed [ERR_W-1:0] ERR_NONE      = 4'sd0;
    localparam logic signed [ERR_W-1:0] ERR_LEFT      = 4'sd1;
    localparam logic signed [ERR_W-1:0] ERR_RIGHT     = -4'sd1;
    localparam logic signed [ERR_W-1:0] ERR_FAR_LEFT  = 4'sd4;
    localparam logic signed [ERR_W-1:0] ERR_FAR_RIGHT = -4'sd4;

    localparam logic [ELAP_W-1:0] MIN_ELAPSED = 16'd2;
    localparam logic [RUN_W-1:0]  RUN_MAX     = 16'hFFFF;
    localparam logic [1:0]        HITS_MAX    = 2'd3;

    localparam logic signed [SUM_W-1:0]   DRIVE_HI    = 32'sd40000;
    localparam logic signed [SUM_W-1:0]   DRIVE_LO    = -32'sd40000;
    localparam logic signed [DRIVE_W-1:0] BRAKE_DRIVE = -17'sd255;

    function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [SUM_W-1:0] v);
        logic signed [DRIVE_W-1:0] r;
        if (v > DRIVE_HI) begin
            r = DRIVE_W'(DRIVE_HI);
        end else if (v < DRIVE_LO) begin
            r = DRIVE_W'(DRIVE_LO);
        end else begin
            r = DRIVE_W'(v);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/lfpid_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module lfpid_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lfpid_pkg::NUM_W-1:0] i_num,
    input  logic [lfpid_pkg::DEN_W-1:0] i_den,
    output logic                        o_done,
    output logic [lfpid_pkg::NUM_W-1:0] o_quot
);
    import lfpid_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_fit;

    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_fit   = (w_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ rtl/core/line_follow_pid_controller.sv @@
`timescale 1ns / 1ps

// PID line follower controller. Each input word carries a command and one sensor
// sample (ambient and lit readings of the left, right and edge sensors, plus the
// elapsed time). A steering sample passes the evaluate, integrate, numerator,
// divider start, divide, sum and done states in turn. One 16x16 multiplier is
// shared for the integral product, the derivative numerator and the derivative
// divisor, formed in the evaluate, integrate and numerator states. A restoring
// divider then forms the derivative quotient: a load step and 16 quotient bits.
// The sum state adds the terms and the done state hands the word over. Start,
// stop, halted and too-early words go from idle straight to the done state, a
// brake through the evaluate state first; a stalled output register holds the
// done state. o_in_stall is high from acceptance until the sequencer is back in
// idle; a finished word waits in the output register while the next one is
// accepted. The user must write configuration through i_cfg_we / i_cfg_index /
// i_cfg_data only while idle; the block itself does not enforce this.
module line_follow_pid_controller #(
    parameter int ADC_BITS       = 12,
    parameter int INTEGRAL_LIMIT = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [lfpid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lfpid_pkg::THR_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lfpid_pkg::CMD_W-1:0]          i_cmd,
    input  logic [ADC_BITS-1:0]                  i_amb_left,
    input  logic [ADC_BITS-1:0]                  i_amb_right,
    input  logic [ADC_BITS-1:0]                  i_amb_edge,
    input  logic [ADC_BITS-1:0]                  i_lit_left,
    input  logic [ADC_BITS-1:0]                  i_lit_right,
    input  logic [ADC_BITS-1:0]                  i_lit_edge,
    input  logic [lfpid_pkg::ELAP_W-1:0]         i_elapsed_ms,
    input  logic signed [lfpid_pkg::THR_W-1:0]   i_stop_left,
    input  logic signed [lfpid_pkg::THR_W-1:0]   i_stop_right,
    input  logic signed [lfpid_pkg::THR_W-1:0]   i_stop_edge,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [lfpid_pkg::ACT_W-1:0]          o_action,
    output logic signed [lfpid_pkg::DRIVE_W-1:0] o_left_drive,
    output logic signed [lfpid_pkg::DRIVE_W-1:0] o_right_drive,
    output logic signed [lfpid_pkg::ERR_W-1:0]   o_line_error,
    output logic                                 o_running
);
    import lfpid_pkg::*;

    // sensor level is ambient minus lit
    localparam int LVL_W = ADC_BITS + 1;
    // stop levels must hold 1 << ADC_BITS and any 14-bit input
    localparam int SL_W  = (ADC_BITS + 2 > THR_W) ? ADC_BITS + 2 : THR_W;
    localparam int IA_W  = $clog2(INTEGRAL_LIMIT + 1) + 1;

    localparam logic signed [SL_W-1:0]  STOP_RESET = SL_W'(1 << ADC_BITS);
    localparam logic signed [THR_W-1:0] THR_RESET  = 14'sd2048;
    localparam logic signed [SUM_W-1:0] ILIM_POS   = SUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [SUM_W-1:0] ILIM_NEG   = -ILIM_POS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EVAL   = 8'b0000_0010,
        S_INTEG  = 8'b0000_0100,
        S_NUM    = 8'b0000_1000,
        S_DSTART = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_SUM    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic signed [THR_W-1:0] r_left_thr;
    logic signed [THR_W-1:0] r_right_thr;
    logic [GAIN_W-1:0]       r_gain_p;
    logic [GAIN_W-1:0]       r_gain_i;
    logic [GAIN_W-1:0]       r_gain_d;
    logic [BASE_W-1:0]       r_base;

    // controller state
    logic                    r_run_active;
    logic signed [ERR_W-1:0] r_last_err;
    logic [RUN_W-1:0]        r_same_run;
    logic [1:0]              r_stop_hits;
    logic signed [IA_W-1:0]  r_integ;
    logic signed [SL_W-1:0]  r_stop_l;
    logic signed [SL_W-1:0]  r_stop_r;
    logic signed [SL_W-1:0]  r_stop_e;

    // working registers of one sample
    logic signed [LVL_W-1:0] r_lvl_l;
    logic signed [LVL_W-1:0] r_lvl_r;
    logic signed [LVL_W-1:0] r_lvl_e;
    logic [ELAP_W-1:0]       r_elapsed;
    logic signed [ERR_W-1:0] r_err;
    logic                    r_dneg;
    logic [3:0]              r_dmag;
    logic [DEN_W-1:0]        r_prod;
    logic [NUM_W-1:0]        r_num;

    // finished word waiting for the output register
    logic [ACT_W-1:0]          r_res_action;
    logic signed [DRIVE_W-1:0] r_res_left;
    logic signed [DRIVE_W-1:0] r_res_right;
    logic signed [ERR_W-1:0]   r_res_err;
    logic                      r_res_run;

    // output register
    logic                      r_out_valid;
    logic [ACT_W-1:0]          r_out_action;
    logic signed [DRIVE_W-1:0] r_out_left;
    logic signed [DRIVE_W-1:0] r_out_right;
    logic signed [ERR_W-1:0]   r_out_err;
    logic                      r_out_run;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_load_out;
    logic                    w_sample;
    logic signed [LVL_W-1:0] w_lvl_l;
    logic signed [LVL_W-1:0] w_lvl_r;
    logic signed [LVL_W-1:0] w_lvl_e;
    logic                    w_stop_hit;
    logic [1:0]              n_stop_hits;
    logic                    w_brake;
    logic                    w_see_l;
    logic                    w_see_r;
    logic signed [ERR_W-1:0] n_err;
    logic signed [4:0]       w_diff;
    logic signed [4:0]       w_diff_neg;
    logic [RUN_W-1:0]        n_same_run;
    logic [NUM_W-1:0]        w_mul_a;
    logic [NUM_W-1:0]        w_mul_b;
    logic [DEN_W-1:0]        w_mul;
    logic                    w_err_far;
    logic [DEN_W-1:0]        w_tmag;
    logic signed [SUM_W-1:0] w_term;
    logic signed [SUM_W-1:0] w_isum;
    logic signed [IA_W-1:0]  n_integ;
    logic [SUM_W-1:0]        w_pmag;
    logic signed [SUM_W-1:0] w_p;
    logic signed [SUM_W-1:0] w_d;
    logic signed [SUM_W-1:0] w_g;
    logic signed [SUM_W-1:0] w_left_raw;
    logic signed [SUM_W-1:0] w_right_raw;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [NUM_W-1:0]        w_quot;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = (r_state == S_DONE) && w_out_free;
    // a word that goes through the controller loop
    assign w_sample   = (i_cmd == CMD_SAMPLE) && r_run_active && (i_elapsed_ms >= MIN_ELAPSED);
    assign w_div_start = (r_state == S_DSTART);

    always_comb begin
        w_lvl_l = $signed({1'b0, i_amb_left})  - $signed({1'b0, i_lit_left});
        w_lvl_r = $signed({1'b0, i_amb_right}) - $signed({1'b0, i_lit_right});
        w_lvl_e = $signed({1'b0, i_amb_edge})  - $signed({1'b0, i_lit_edge});

        // stop marker: all three levels under their stop levels
        w_stop_hit = (SL_W'(r_lvl_l) < r_stop_l) && (SL_W'(r_lvl_r) < r_stop_r) &&
                     (SL_W'(r_lvl_e) < r_stop_e);
        if (!w_stop_hit) begin
            n_stop_hits = 2'd0;
        end else if (r_stop_hits == HITS_MAX) begin
            n_stop_hits = HITS_MAX;
        end else begin
            n_stop_hits = r_stop_hits + 2'd1;
        end
        w_brake = w_stop_hit && (n_stop_hits > 2'd1);

        // line classification; line lost on both sides pushes the last error out
        w_see_l = SL_W'(r_lvl_l) < SL_W'(r_left_thr);
        w_see_r = SL_W'(r_lvl_r) < SL_W'(r_right_thr);
        if (w_see_l && w_see_r) begin
            n_err = ERR_NONE;
        end else if (w_see_l) begin
            n_err = ERR_LEFT;
        end else if (w_see_r) begin
            n_err = ERR_RIGHT;
        end else if (r_last_err == ERR_NONE) begin
            n_err = ERR_NONE;
        end else if (r_last_err[ERR_W-1]) begin
            n_err = ERR_FAR_RIGHT;
        end else begin
            n_err = ERR_FAR_LEFT;
        end

        w_diff     = 5'(n_err) - 5'(r_last_err);
        w_diff_neg = -w_diff;

        if (n_err != r_last_err) begin
            n_same_run = RUN_W'(1);
        end else if (r_same_run == RUN_MAX) begin
            n_same_run = RUN_MAX;
        end else begin
            n_same_run = r_same_run + RUN_W'(1);
        end
    end

    // shared multiplier: gain_i*elapsed, gain_d*|delta|, elapsed*run
    always_comb begin
        case (r_state)
            S_EVAL: begin
                w_mul_a = NUM_W'(r_gain_i);
                w_mul_b = NUM_W'(r_elapsed);
            end
            S_INTEG: begin
                w_mul_a = NUM_W'(r_gain_d);
                w_mul_b = NUM_W'(r_dmag);
            end
            S_NUM: begin
                w_mul_a = NUM_W'(r_elapsed);
                w_mul_b = NUM_W'(r_same_run);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // error is 0, +-1 or +-4, so scaling by it is a shift and a negate
    always_comb begin
        w_err_far = (r_err == ERR_FAR_LEFT) || (r_err == ERR_FAR_RIGHT);

        w_tmag = w_err_far ? {r_prod[DEN_W-3:0], 2'b00} : r_prod;
        if (r_err == ERR_NONE) begin
            w_term = '0;
        end else if (r_err[ERR_W-1]) begin
            w_term = -$signed(w_tmag);
        end else begin
            w_term = $signed(w_tmag);
        end
        w_isum = SUM_W'(r_integ) + w_term;
        if (w_isum > ILIM_POS) begin
            n_integ = IA_W'(ILIM_POS);
        end else if (w_isum < ILIM_NEG) begin
            n_integ = IA_W'(ILIM_NEG);
        end else begin
            n_integ = IA_W'(w_isum);
        end

        w_pmag = w_err_far ? (SUM_W'(r_gain_p) << 2) : SUM_W'(r_gain_p);
        if (r_err == ERR_NONE) begin
            w_p = '0;
        end else if (r_err[ERR_W-1]) begin
            w_p = -$signed(w_pmag);
        end else begin
            w_p = $signed(w_pmag);
        end

        // magnitude quotient with the sign put back: truncates toward zero
        w_d = r_dneg ? -$signed(SUM_W'(w_quot)) : $signed(SUM_W'(w_quot));

        w_g         = w_p + SUM_W'(r_integ) + w_d;
        w_left_raw  = $signed(SUM_W'(r_base)) - w_g;
        w_right_raw = $signed(SUM_W'(r_base)) + w_g;
    end

    lfpid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_prod),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // sequencer, configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_left_thr   <= THR_RESET;
            r_right_thr  <= THR_RESET;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_base       <= '0;
            r_run_active <= 1'b0;
            r_last_err   <= ERR_NONE;
            r_same_run   <= '0;
            r_stop_hits  <= '0;
            r_integ      <= '0;
            r_stop_l     <= STOP_RESET;
            r_stop_r     <= STOP_RESET;
            r_stop_e     <= STOP_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEFT_THR:  r_left_thr  <= $signed(i_cfg_data);
                    CFG_RIGHT_THR: r_right_thr <= $signed(i_cfg_data);
                    CFG_GAIN_P:    r_gain_p    <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:    r_gain_i    <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:    r_gain_d    <= i_cfg_data[GAIN_W-1:0];
                    CFG_BASE:      r_base      <= i_cfg_data[BASE_W-1:0];
                    default: ;
                endcase
            end

            if (w_out_free) begin
                r_out_valid <= w_load_out;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_sample ? S_EVAL : S_DONE;
                        case (i_cmd)
                            CMD_START: begin
                                r_stop_l     <= SL_W'(i_stop_left);
                                r_stop_r     <= SL_W'(i_stop_right);
                                r_stop_e     <= SL_W'(i_stop_edge);
                                r_last_err   <= ERR_NONE;
                                r_same_run   <= '0;
                                r_stop_hits  <= '0;
                                r_integ      <= '0;
                                r_run_active <= 1'b1;
                            end
                            CMD_STOP: begin
                                r_run_active <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EVAL: begin
                    r_stop_hits <= n_stop_hits;
                    if (w_brake) begin
                        r_run_active <= 1'b0;
                        r_state      <= S_DONE;
                    end else begin
                        r_last_err <= n_err;
                        r_same_run <= n_same_run;
                        r_state    <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    r_integ <= n_integ;
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath and result words, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_lvl_l      <= w_lvl_l;
                r_lvl_r      <= w_lvl_r;
                r_lvl_e      <= w_lvl_e;
                r_elapsed    <= i_elapsed_ms;
                r_res_left   <= '0;
                r_res_right  <= '0;
                r_res_err    <= ERR_NONE;
                case (i_cmd)
                    CMD_START: begin
                        r_res_action <= ACT_IDLE;
                        r_res_run    <= 1'b1;
                    end
                    CMD_STOP: begin
                        r_res_action <= ACT_IDLE;
                        r_res_run    <= 1'b0;
                    end
                    CMD_SAMPLE: begin
                        // halted gives idle, running but too soon gives early
                        r_res_action <= r_run_active ? ACT_EARLY : ACT_IDLE;
                        r_res_run    <= r_run_active;
                    end
                    default: begin
                        r_res_action <= ACT_IDLE;
                        r_res_run    <= r_run_active;
                    end
                endcase
            end
            S_EVAL: begin
                r_err  <= n_err;
                r_dneg <= w_diff[4];
                r_dmag <= w_diff[4] ? w_diff_neg[3:0] : w_diff[3:0];
                r_prod <= w_mul;
                r_res_action <= ACT_BRAKE;
                r_res_left   <= BRAKE_DRIVE;
                r_res_right  <= BRAKE_DRIVE;
                r_res_err    <= ERR_NONE;
                r_res_run    <= 1'b0;
            end
            S_INTEG: begin
                r_prod <= w_mul;
            end
            S_NUM: begin
                r_num  <= r_prod[NUM_W-1:0];
                r_prod <= w_mul;
            end
            S_SUM: begin
                r_res_action <= ACT_STEER;
                r_res_left   <= sat_drive(w_left_raw);
                r_res_right  <= sat_drive(w_right_raw);
                r_res_err    <= r_err;
                r_res_run    <= 1'b1;
            end
            default: ;
        endcase

        if (w_load_out) begin
            r_out_action <= r_res_action;
            r_out_left   <= r_res_left;
            r_out_right  <= r_res_right;
            r_out_err    <= r_res_err;
            r_out_run    <= r_res_run;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out_action;
    assign o_left_drive  = r_out_left;
    assign o_right_drive = r_out_right;
    assign o_line_error  = r_out_err;
    assign o_running     = r_out_run;

endmodule
